// File: rtl/mcbp_pkg.sv
package mcbp_pkg;

  localparam int unsigned PID_W       = 15;
  localparam int unsigned DESC_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FIRST_DESC_W = 8;

  localparam logic [FIRST_DESC_W-1:0] FIRST_DESC_RST = 8'd3;
  localparam logic [BYTE_W-1:0]       END_BYTE       = 8'hFF;

  typedef enum logic [2:0] {
    ACT_OPEN_RD = 3'd0,
    ACT_OPEN_WR = 3'd1,
    ACT_CLOSE   = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_READ    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_ERROR     = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_ENDED     = 3'd5
  } status_e;

endpackage

// File: rtl/mcbp_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module mcbp_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/multi_channel_byte_pipe_unit.sv
// Accepted transactions go to stage B, are decided there, then go to the output register.
// Throughput: one transaction per cycle unless the response stalls, also back to back
//   on the same pipe; the slot-state RAM read and the byte RAM read are both registered.
// Reset (rst_ni low, async): all pipes inactive, first_descriptor = 3, pipeline empty.
//   Pipe state is qualified by per-slot active flops, so no clearing pass is needed.
module multi_channel_byte_pipe_unit
  import mcbp_pkg::*;
#(
  parameter int unsigned NUM_PIPES  = 64,
  parameter int unsigned PIPE_DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config channel: first_descriptor
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [FIRST_DESC_W-1:0] cfg_data_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              action_i,
  input  logic [DESC_W-1:0]       descriptor_i,
  input  logic [PID_W-1:0]        process_id_i,
  input  logic [BYTE_W-1:0]       write_data_i,
  // response channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [BYTE_W-1:0]       read_data_o
);

  localparam int unsigned SLOT_W     = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int unsigned PTR_W      = $clog2(PIPE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);
  localparam int unsigned BYTE_DEPTH = NUM_PIPES * PIPE_DEPTH;
  localparam int unsigned BADDR_W    = $clog2(BYTE_DEPTH);

  // Per-pipe bookkeeping, one word per slot in the slot RAM.
  typedef struct packed {
    logic              wr_present;
    logic [PID_W-1:0]  wr_owner;
    logic              rd_present;
    logic [PID_W-1:0]  rd_owner;
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  fill;
    logic              ended;
  } slot_t;

  localparam int unsigned SLOT_BITS = $bits(slot_t);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [FIRST_DESC_W-1:0] first_desc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_desc_q <= FIRST_DESC_RST;
    end else if (cfg_valid_i) begin
      first_desc_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipe moves when the output register can take
  // a new transaction.
  // ---------------------------------------------------------------------------
  logic advance;
  logic c_valid_q;

  assign advance    = !c_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // ---------------------------------------------------------------------------
  // Input side: map descriptor to slot, issue the slot-state read.
  // ---------------------------------------------------------------------------
  logic [DESC_W-1:0] desc_diff;
  logic              in_found;
  logic [SLOT_W-1:0] in_slot;

  assign desc_diff = descriptor_i - DESC_W'(first_desc_q);
  assign in_found  = (descriptor_i >= DESC_W'(first_desc_q)) &&
                     (desc_diff < DESC_W'(NUM_PIPES));
  assign in_slot   = in_found ? desc_diff[SLOT_W-1:0] : '0;

  // Stage B registers (item being decided)
  logic              b_valid_q;
  logic [2:0]        b_action_q;
  logic              b_found_q;
  logic [SLOT_W-1:0] b_slot_q;
  logic [PID_W-1:0]  b_pid_q;
  logic [BYTE_W-1:0] b_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_action_q <= action_i;
      b_found_q  <= in_found;
      b_slot_q   <= in_slot;
      b_pid_q    <= process_id_i;
      b_data_q   <= write_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot state: RAM plus active flops, with a bypass for the write that
  // lands on the same edge as the read.
  // ---------------------------------------------------------------------------
  logic [NUM_PIPES-1:0] slot_active_q;
  logic [SLOT_BITS-1:0] slot_rdata;
  logic                 slot_we;
  slot_t                slot_nxt;
  logic                 act_nxt;
  logic                 slot_wr;

  logic                 fwd_valid_q;
  logic [SLOT_W-1:0]    fwd_slot_q;
  slot_t                fwd_data_q;

  mcbp_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (NUM_PIPES),
    .ADDR_W(SLOT_W)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(b_slot_q),
    .wdata_i(slot_nxt),
    .re_i   (advance),
    .raddr_i(in_slot),
    .rdata_o(slot_rdata)
  );

  logic  cur_active;
  slot_t cur;

  always_comb begin
    cur_active = slot_active_q[b_slot_q];
    if (!cur_active) begin
      cur = '0;                       // inactive slot reads as cleared
    end else if (fwd_valid_q && (fwd_slot_q == b_slot_q)) begin
      cur = fwd_data_q;
    end else begin
      cur = slot_t'(slot_rdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Decision logic
  // ---------------------------------------------------------------------------
  status_e           b_status;
  logic [BYTE_W-1:0] b_rdata;
  logic              b_use_ram;
  logic              byte_we;
  logic              byte_re;
  logic              wr_own;
  logic              rd_own;
  logic              live;

  assign live   = b_found_q && cur_active;
  assign wr_own = cur.wr_present && (cur.wr_owner == b_pid_q);
  assign rd_own = cur.rd_present && (cur.rd_owner == b_pid_q);

  always_comb begin
    slot_nxt  = cur;
    act_nxt   = cur_active;
    slot_wr   = 1'b0;
    b_status  = ST_ERROR;
    b_rdata   = '0;
    b_use_ram = 1'b0;
    byte_we   = 1'b0;
    byte_re   = 1'b0;
    case (b_action_q)
      ACT_OPEN_RD, ACT_OPEN_WR: begin
        if (!b_found_q) begin
          b_status = ST_NOT_FOUND;
        end else begin
          // opening an inactive slot sets it up even if the open fails
          act_nxt = 1'b1;
          slot_wr = 1'b1;
          if (b_action_q == ACT_OPEN_RD && !cur.rd_present) begin
            slot_nxt.rd_present = 1'b1;
            slot_nxt.rd_owner   = b_pid_q;
            b_status            = ST_OK;
          end else if (b_action_q == ACT_OPEN_WR && !cur.wr_present) begin
            slot_nxt.wr_present = 1'b1;
            slot_nxt.wr_owner   = b_pid_q;
            b_status            = ST_OK;
          end
        end
      end
      ACT_CLOSE: begin
        if (live && wr_own) begin
          // writer goes, buffered data stays
          slot_nxt.wr_present = 1'b0;
          slot_nxt.wr_owner   = '0;
          slot_wr             = 1'b1;
          b_status            = ST_OK;
        end else if (live && rd_own) begin
          slot_nxt = '0;
          act_nxt  = 1'b0;
          slot_wr  = 1'b1;
          b_status = ST_OK;
        end
      end
      ACT_WRITE: begin
        if (live && wr_own) begin
          if (cur.ended) begin
            b_status = ST_ENDED;
          end else if (cur.fill == CNT_W'(PIPE_DEPTH)) begin
            b_status = ST_FULL;
          end else if (b_data_q == END_BYTE) begin
            slot_nxt.ended = 1'b1;
            slot_wr        = 1'b1;
            b_status       = ST_OK;
          end else begin
            byte_we         = 1'b1;
            slot_nxt.wr_ptr = (cur.wr_ptr == PTR_W'(PIPE_DEPTH - 1)) ? '0 :
                              cur.wr_ptr + 1'b1;
            slot_nxt.fill   = cur.fill + 1'b1;
            slot_wr         = 1'b1;
            b_status        = ST_OK;
          end
        end
      end
      ACT_READ: begin
        if (live && rd_own) begin
          if (cur.fill != '0) begin
            byte_re         = 1'b1;
            b_use_ram       = 1'b1;
            slot_nxt.rd_ptr = (cur.rd_ptr == PTR_W'(PIPE_DEPTH - 1)) ? '0 :
                              cur.rd_ptr + 1'b1;
            slot_nxt.fill   = cur.fill - 1'b1;
            slot_wr         = 1'b1;
            b_status        = ST_OK;
          end else if (cur.ended) begin
            b_rdata  = END_BYTE;
            b_status = ST_ENDED;
          end else begin
            b_status = ST_EMPTY;
          end
        end
      end
      default: begin
        b_status = ST_ERROR;
      end
    endcase
  end

  logic commit;

  assign commit  = advance && b_valid_q;
  assign slot_we = commit && slot_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_active_q <= '0;
      fwd_valid_q   <= 1'b0;
    end else if (slot_we) begin
      slot_active_q[b_slot_q] <= act_nxt;
      fwd_valid_q             <= 1'b1;
    end
  end

  // most recent slot write, needed by the next transaction's stale RAM read
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      fwd_slot_q <= b_slot_q;
      fwd_data_q <= slot_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte store: pipe s owns entries s*PIPE_DEPTH .. s*PIPE_DEPTH+PIPE_DEPTH-1
  // ---------------------------------------------------------------------------
  logic [BADDR_W-1:0] byte_base;
  logic [BADDR_W-1:0] byte_waddr;
  logic [BADDR_W-1:0] byte_raddr;
  logic [BYTE_W-1:0]  byte_rdata;

  assign byte_base  = BADDR_W'(b_slot_q) * BADDR_W'(PIPE_DEPTH);
  assign byte_waddr = byte_base + BADDR_W'(cur.wr_ptr);
  assign byte_raddr = byte_base + BADDR_W'(cur.rd_ptr);

  mcbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BYTE_DEPTH),
    .ADDR_W(BADDR_W)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (commit && byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(b_data_q),
    .re_i   (commit && byte_re),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output register. Byte data of a successful read comes straight from the
  // byte RAM read register, which holds while the output stalls.
  // ---------------------------------------------------------------------------
  status_e           c_status_q;
  logic [BYTE_W-1:0] c_rdata_q;
  logic              c_use_ram_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (advance) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      c_status_q  <= b_status;
      c_rdata_q   <= b_rdata;
      c_use_ram_q <= b_use_ram;
    end
  end

  assign out_valid_o = c_valid_q;
  assign status_o    = c_status_q;
  assign read_data_o = c_use_ram_q ? byte_rdata : c_rdata_q;

endmodule

// File: rtl/mcbp_checker.sv
module mcbp_checker
  import mcbp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [2:0]        status_o,
  input logic [BYTE_W-1:0] read_data_o
);

  // held response stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // every accepted transaction is followed by a presented response
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("response missing after accepted transaction");

  // request side only backs up behind a stalled response
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request side stalled without output backpressure");

  // only ok and ended may carry data
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK && status_o != ST_ENDED |-> read_data_o == '0)
    else $error("nonzero read data on failing status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_ENDED)
    else $error("status code out of range");

endmodule

bind multi_channel_byte_pipe_unit mcbp_checker u_mcbp_checker (.*);

// File: tb/multi_channel_byte_pipe_unit_tb.sv
module multi_channel_byte_pipe_unit_tb
  import mcbp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PIPES  = 64;
  localparam int unsigned PIPE_DEPTH = 256;

  // Action codes the block does not define; they must answer ST_ERROR.
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;

  localparam logic [PID_W-1:0]  PID_MAX    = '1;
  localparam logic [DESC_W-1:0] DESC_MAX   = '1;
  // Descriptors around the table while first_descriptor is at its reset value.
  localparam logic [DESC_W-1:0] SLOT0_DESC = DESC_W'(FIRST_DESC_RST);
  localparam logic [DESC_W-1:0] LAST_DESC  = DESC_W'(SLOT0_DESC + NUM_PIPES - 1);
  localparam logic [DESC_W-1:0] PAST_DESC  = DESC_W'(SLOT0_DESC + NUM_PIPES);

  typedef struct {
    status_e           st;
    logic [BYTE_W-1:0] rd;
  } reply_t;

  // One directed transaction; a typed-in reply is used where 'typed' is set.
  typedef struct {
    logic [2:0]        act;
    logic [DESC_W-1:0] desc;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] data;
    bit                typed;
    status_e           st;
    logic [BYTE_W-1:0] rd;
  } probe_row_t;

  // ---------------------------------------------------------------------------
  // Clock, DUT ports
  // ---------------------------------------------------------------------------
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [FIRST_DESC_W-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              action_i = '0;
  logic [DESC_W-1:0]       descriptor_i = '0;
  logic [PID_W-1:0]        process_id_i = '0;
  logic [BYTE_W-1:0]       write_data_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b1;
  logic [2:0]              status_o;
  logic [BYTE_W-1:0]       read_data_o;

  always #2 clk_i = ~clk_i;

  multi_channel_byte_pipe_unit #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_DEPTH (PIPE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .descriptor_i (descriptor_i),
    .process_id_i (process_id_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o)
  );

  // ---------------------------------------------------------------------------
  // Pipe table shadow: per-slot ownership, pointers, fill and end mark
  // ---------------------------------------------------------------------------
  logic [FIRST_DESC_W-1:0] first_desc;
  bit                      slot_live [NUM_PIPES];
  bit                      wr_held   [NUM_PIPES];
  logic [PID_W-1:0]        wr_pid    [NUM_PIPES];
  bit                      rd_held   [NUM_PIPES];
  logic [PID_W-1:0]        rd_pid    [NUM_PIPES];
  int unsigned             rd_ptr    [NUM_PIPES];
  int unsigned             wr_ptr    [NUM_PIPES];
  int unsigned             fill      [NUM_PIPES];
  bit                      eos       [NUM_PIPES];
  logic [BYTE_W-1:0]       ring      [NUM_PIPES][PIPE_DEPTH];

  reply_t      pending_replies [$];
  int unsigned reply_faults = 0;

  // Pacing knobs; tail_quiet switches off all idling near the end.
  bit          src_gaps    = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          tail_quiet  = 1'b0;
  int unsigned focus_slots [3];

  function automatic void reset_slot(input int unsigned s);
    slot_live[s] = 1'b0;
    wr_held[s]   = 1'b0;
    wr_pid[s]    = '0;
    rd_held[s]   = 1'b0;
    rd_pid[s]    = '0;
    rd_ptr[s]    = 0;
    wr_ptr[s]    = 0;
    fill[s]      = 0;
    eos[s]       = 1'b0;
  endfunction

  // Applies one transaction to the shadow table and returns its reply.
  function automatic void apply_pipe_request(
    input  logic [2:0]        act,
    input  logic [DESC_W-1:0] desc,
    input  logic [PID_W-1:0]  pid,
    input  logic [BYTE_W-1:0] data,
    output status_e           st,
    output logic [BYTE_W-1:0] rd
  );
    int  d;
    int  f;
    int  s;
    bit  hit;
    d   = int'(desc);
    f   = int'(first_desc);
    hit = (d >= f) && (d - f < NUM_PIPES);
    s   = hit ? d - f : 0;
    st  = ST_ERROR;
    rd  = '0;
    case (act)
      ACT_OPEN_RD, ACT_OPEN_WR: begin
        if (!hit) begin
          st = ST_NOT_FOUND;
        end else begin
          // first open of an idle slot sets it up empty, even if the open fails
          if (!slot_live[s]) begin
            reset_slot(s);
            slot_live[s] = 1'b1;
          end
          if (act == ACT_OPEN_RD && !rd_held[s]) begin
            rd_held[s] = 1'b1;
            rd_pid[s]  = pid;
            st         = ST_OK;
          end else if (act == ACT_OPEN_WR && !wr_held[s]) begin
            wr_held[s] = 1'b1;
            wr_pid[s]  = pid;
            st         = ST_OK;
          end
        end
      end
      ACT_CLOSE: begin
        if (hit && slot_live[s]) begin
          // writer side wins when one process owns both
          if (wr_held[s] && wr_pid[s] == pid) begin
            wr_held[s] = 1'b0;
            wr_pid[s]  = '0;
            st         = ST_OK;
          end else if (rd_held[s] && rd_pid[s] == pid) begin
            reset_slot(s);
            st = ST_OK;
          end
        end
      end
      ACT_WRITE: begin
        if (hit && slot_live[s] && wr_held[s] && wr_pid[s] == pid) begin
          if (eos[s]) begin
            st = ST_ENDED;
          end else if (fill[s] >= PIPE_DEPTH) begin
            st = ST_FULL;
          end else if (data == END_BYTE) begin
            eos[s] = 1'b1;
            st     = ST_OK;
          end else begin
            ring[s][wr_ptr[s]] = data;
            wr_ptr[s] = (wr_ptr[s] + 1) % PIPE_DEPTH;
            fill[s]++;
            st = ST_OK;
          end
        end
      end
      ACT_READ: begin
        if (hit && slot_live[s] && rd_held[s] && rd_pid[s] == pid) begin
          if (fill[s] > 0) begin
            rd        = ring[s][rd_ptr[s]];
            rd_ptr[s] = (rd_ptr[s] + 1) % PIPE_DEPTH;
            fill[s]--;
            st = ST_OK;
          end else if (eos[s]) begin
            rd = END_BYTE;
            st = ST_ENDED;
          end else begin
            st = ST_EMPTY;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic probe_row_t probe_row(
    input logic [2:0]        act,
    input logic [DESC_W-1:0] desc,
    input logic [PID_W-1:0]  pid,
    input logic [BYTE_W-1:0] data,
    input bit                typed,
    input status_e           st,
    input logic [BYTE_W-1:0] rd
  );
    probe_row_t row;
    row.act   = act;
    row.desc  = desc;
    row.pid   = pid;
    row.data  = data;
    row.typed = typed;
    row.st    = st;
    row.rd    = rd;
    return row;
  endfunction

  // Mostly legal open/write/read/close traffic on a few focus slots, steered by
  // the shadow ownership; a slice is wrong-owner traffic or plain noise.
  function automatic void pick_request(
    output logic [2:0]        act,
    output logic [DESC_W-1:0] desc,
    output logic [PID_W-1:0]  pid,
    output logic [BYTE_W-1:0] data
  );
    int unsigned s;
    int unsigned r;
    s    = focus_slots[$urandom_range(0, 2)];
    r    = $urandom_range(0, 99);
    desc = DESC_W'(first_desc + s);
    pid  = PID_W'($urandom);
    data = ($urandom_range(0, 39) == 0) ? END_BYTE : BYTE_W'($urandom_range(0, 254));
    act  = ACT_READ;
    if (r < 8) begin
      act  = 3'($urandom);
      desc = DESC_W'($urandom);
      data = BYTE_W'($urandom);
    end else if (!wr_held[s] && !eos[s] && (!slot_live[s] || r < 40)) begin
      act = ACT_OPEN_WR;
      if (rd_held[s] && r < 20) pid = rd_pid[s];
    end else if (!rd_held[s]) begin
      act = ACT_OPEN_RD;
      if (wr_held[s] && r < 20) pid = wr_pid[s];
    end else if (r < 14) begin
      // random pid: almost always a non-owner
      act = (r < 11) ? ACT_WRITE : ACT_READ;
    end else if (r < 17 || (fill[s] == 0 && (eos[s] || !wr_held[s]) && r < 40)) begin
      act = ACT_CLOSE;
      pid = (wr_held[s] && r[0]) ? wr_pid[s] : rd_pid[s];
    end else if (wr_held[s] && (eos[s] ? r < 22 : r < 62)) begin
      act = ACT_WRITE;
      pid = wr_pid[s];
    end else begin
      act = ACT_READ;
      pid = rd_pid[s];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: drive at negedge, one transaction per handshake
  // ---------------------------------------------------------------------------
  task automatic issue_request(
    input logic [2:0]        act,
    input logic [DESC_W-1:0] desc,
    input logic [PID_W-1:0]  pid,
    input logic [BYTE_W-1:0] data,
    input bit                typed,
    input status_e           t_st,
    input logic [BYTE_W-1:0] t_rd
  );
    reply_t reply;
    @(negedge clk_i);
    if (src_gaps && !tail_quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    action_i     = act;
    descriptor_i = desc;
    process_id_i = pid;
    write_data_i = data;
    do @(posedge clk_i); while (!in_ready_o);
    apply_pipe_request(act, desc, pid, data, reply.st, reply.rd);
    if (typed) begin
      reply.st = t_st;
      reply.rd = t_rd;
    end
    pending_replies.push_back(reply);
  endtask

  task automatic push_op(
    input logic [2:0]        act,
    input logic [DESC_W-1:0] desc,
    input logic [PID_W-1:0]  pid,
    input logic [BYTE_W-1:0] data
  );
    issue_request(act, desc, pid, data, 1'b0, ST_OK, '0);
  endtask

  // Stops the sender until every reply is back, plus pipeline slack.
  task automatic drain_replies();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_first_descriptor(input logic [FIRST_DESC_W-1:0] value);
    drain_replies();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    first_desc = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned count, input bit quiet_end);
    logic [2:0]        act;
    logic [DESC_W-1:0] desc;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] data;
    focus_slots[0] = 0;
    focus_slots[1] = NUM_PIPES - 1;
    focus_slots[2] = $urandom_range(1, NUM_PIPES - 2);
    for (int i = 0; i < count; i++) begin
      if (quiet_end && i + 100 >= count) tail_quiet = 1'b1;
      if ($urandom_range(0, 199) == 0) drain_replies();
      pick_request(act, desc, pid, data);
      push_op(act, desc, pid, data);
    end
  endtask

  // Fills an idle pipe to the brim, hits full (also with the end byte), then
  // drains and refills across the pointer wrap before ending the stream.
  task automatic stuff_and_drain();
    int unsigned       s;
    logic [DESC_W-1:0] d;
    logic [PID_W-1:0]  w;
    logic [PID_W-1:0]  r;
    s = $urandom_range(0, NUM_PIPES - 1);
    for (int k = 0; k < NUM_PIPES && slot_live[s]; k++) s = (s + 1) % NUM_PIPES;
    d = DESC_W'(first_desc + s);
    w = PID_W'($urandom);
    r = PID_W'($urandom);
    push_op(ACT_OPEN_WR, d, w, '0);
    push_op(ACT_OPEN_RD, d, r, '0);
    repeat (PIPE_DEPTH) push_op(ACT_WRITE, d, w, BYTE_W'($urandom_range(0, 254)));
    push_op(ACT_WRITE, d, w, END_BYTE);
    push_op(ACT_WRITE, d, w, BYTE_W'($urandom_range(0, 254)));
    repeat (200) push_op(ACT_READ, d, r, '0);
    repeat (100) push_op(ACT_WRITE, d, w, BYTE_W'($urandom_range(0, 254)));
    repeat (PIPE_DEPTH - 100 + 1) push_op(ACT_READ, d, r, '0);
    push_op(ACT_WRITE, d, w, END_BYTE);
    push_op(ACT_READ, d, r, '0);
    push_op(ACT_CLOSE, d, w, '0);
    push_op(ACT_CLOSE, d, r, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random backpressure, checked at posedge
  // ---------------------------------------------------------------------------
  always begin : sink_pacing
    @(negedge clk_i);
    if (sink_stalls && !tail_quiet && $urandom_range(0, 5) == 0) begin
      out_ready_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
      out_ready_i = 1'b1;
    end
  end

  // Flip idling on and off so that quiet stretches show up too.
  always begin : gap_modes
    repeat ($urandom_range(40, 400)) @(posedge clk_i);
    src_gaps    = 1'($urandom_range(0, 1));
    sink_stalls = 1'($urandom_range(0, 1));
  end

  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        reply_faults++;
        if (reply_faults <= 10)
          $display("%0t: reply with nothing outstanding: status=%0d read_data=%02h",
                   $realtime, status_o, read_data_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.st || read_data_o !== want.rd) begin
          reply_faults++;
          if (reply_faults <= 10)
            $display("%0t: mismatch: status exp %0d got %0d, read_data exp %02h got %02h",
                     $realtime, want.st, status_o, want.rd, read_data_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : main_seq
    probe_row_t probe_rows [$];
    first_desc = FIRST_DESC_RST;
    for (int s = 0; s < NUM_PIPES; s++) reset_slot(s);

    // Slot 0 is driven with writer PID_MAX and reader pid 0; slot 63 with one
    // process owning both sides. first_descriptor stays at its reset value here.
    probe_rows.push_back(probe_row(ACT_OPEN_RD, SLOT0_DESC - 1'b1, '0, '0, 1, ST_NOT_FOUND, '0));
    probe_rows.push_back(probe_row(ACT_OPEN_WR, PAST_DESC, '0, '0, 1, ST_NOT_FOUND, '0));
    probe_rows.push_back(probe_row(ACT_CLOSE, DESC_MAX, PID_MAX, '0, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, SLOT0_DESC, '0, 8'h55, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_READ, SLOT0_DESC, '0, '0, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_RSVD_LO, SLOT0_DESC, '0, '0, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_RSVD_HI, SLOT0_DESC, PID_MAX, '0, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_OPEN_WR, SLOT0_DESC, PID_MAX, '0, 1, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_OPEN_WR, SLOT0_DESC, 15'h1234, '0, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_OPEN_RD, SLOT0_DESC, '0, '0, 1, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, SLOT0_DESC, '0, 8'h01, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, SLOT0_DESC, PID_MAX, 8'h00, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, SLOT0_DESC, PID_MAX, 8'hFE, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_READ, SLOT0_DESC, PID_MAX, '0, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_READ, SLOT0_DESC, '0, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_READ, SLOT0_DESC, '0, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_READ, SLOT0_DESC, '0, '0, 1, ST_EMPTY, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, SLOT0_DESC, PID_MAX, END_BYTE, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, SLOT0_DESC, PID_MAX, 8'h12, 1, ST_ENDED, '0));
    probe_rows.push_back(probe_row(ACT_READ, SLOT0_DESC, '0, '0, 1, ST_ENDED, END_BYTE));
    probe_rows.push_back(probe_row(ACT_CLOSE, SLOT0_DESC, PID_MAX, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_CLOSE, SLOT0_DESC, '0, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_OPEN_RD, LAST_DESC, 15'h2AAA, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_OPEN_WR, LAST_DESC, 15'h2AAA, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_CLOSE, LAST_DESC, 15'h2AAA, '0, 0, ST_OK, '0));
    probe_rows.push_back(probe_row(ACT_WRITE, LAST_DESC, 15'h2AAA, 8'h80, 1, ST_ERROR, '0));
    probe_rows.push_back(probe_row(ACT_CLOSE, LAST_DESC, 15'h2AAA, '0, 0, ST_OK, '0));

    // async reset held, then released away from the active edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probe_rows[i])
      issue_request(probe_rows[i].act, probe_rows[i].desc, probe_rows[i].pid,
                    probe_rows[i].data, probe_rows[i].typed, probe_rows[i].st,
                    probe_rows[i].rd);

    // Random traffic under several table offsets, both extremes included.
    load_first_descriptor('0);
    run_random_phase(150, 1'b0);
    load_first_descriptor('1);
    stuff_and_drain();
    run_random_phase(150, 1'b0);
    load_first_descriptor(FIRST_DESC_W'($urandom_range(1, 254)));
    run_random_phase(150, 1'b0);
    load_first_descriptor(FIRST_DESC_RST);
    run_random_phase(150, 1'b1);

    drain_replies();
    if (reply_faults == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
